[src/multi_level_peak_decimator_unit_defines.svh]
// Assertion helpers shared by the decimator RTL.
`ifndef MULTI_LEVEL_PEAK_DECIMATOR_UNIT_DEFINES_SVH
`define MULTI_LEVEL_PEAK_DECIMATOR_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define MLPD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Check that a condition is followed by a consequence in the next cycle.
`define MLPD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/mlpd_pkg.sv]
package mlpd_pkg;

	localparam int NUM_REGS    = 6;
	localparam int REG_IDX_W   = 3;
	localparam int BLK_W       = 16;
	localparam int SAMPLE_W    = 16;
	localparam int CODE_W      = 8;
	localparam int LEVEL_W     = 3;
	localparam int QUEUE_DEPTH = 2;

	typedef logic [BLK_W-1:0] blk_len_t;
	typedef blk_len_t [NUM_REGS-1:0] blk_arr_t;

	localparam blk_len_t BLK_RESET [NUM_REGS] = '{
		16'd16, 16'd32, 16'd64, 16'd128, 16'd256, 16'd512
	};

	localparam logic signed [SAMPLE_W-1:0] RUN_MIN_RESET = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] RUN_MAX_RESET = 16'sh8000;

	typedef struct packed {
		logic                       ch;
		logic signed [SAMPLE_W-1:0] sample;
		logic [CODE_W-1:0]          code0;
	} item_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               ch;
		logic [CODE_W-1:0]  lo;
		logic [CODE_W-1:0]  hi;
	} res_t;

	// ((x + 32768) * 255) >> 16
	function automatic logic [CODE_W-1:0] map_code(input logic signed [SAMPLE_W-1:0] x);
		logic [SAMPLE_W-1:0]        biased;
		logic [SAMPLE_W+CODE_W-1:0] prod;
		biased = {~x[SAMPLE_W-1], x[SAMPLE_W-2:0]};
		prod   = {biased, 8'd0} - {8'd0, biased};
		return prod[SAMPLE_W+CODE_W-1:SAMPLE_W];
	endfunction

endpackage

[src/multi_level_peak_decimator_unit.sv]
// Multi-level min/max peak decimator.
// Input stream: one request per audio sample; s_tdata is the signed Q1.15
// sample, s_tuser the channel. Requests for a channel at or above CHANNELS
// are taken and dropped without results.
// Output stream: per request, first the level 0 entry (mapped sample in both
// codes), then one entry per level 1..LEVELS whose block completes, in
// increasing level order; m_tlast marks the final entry of the request.
// Block lengths are written through cfg_we/cfg_idx/cfg_wdata; the user must
// write them only while idle, as the unit itself does not enforce this.
// The back-end sequencer visits level 0, then one level of running state per
// cycle unless a result waits on a stalled output, then closes the request
// and pops the next queued request in that closing step. Each entry is held
// in a pending register until the next one (or the close) shows whether it
// is the last, and only then enters the output register. A two-entry queue
// between the input side and the sequencer keeps requests flowing in while
// results drain. A stalled m_tready holds the output register and halts the
// sequencer once it has a result to pass on; the input side stalls only once
// the queue fills. Reset clears all running min/max/count state and restores
// the default block lengths 16, 32, 64, 128, 256 and 512.
module multi_level_peak_decimator_unit #(
	parameter int CHANNELS = 2,
	parameter int LEVELS   = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] sample
	input  logic [0:0]  s_tuser,   // [0] channel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] low_code, [15:8] high_code
	output logic [3:0]  m_tuser,   // [2:0] level, [3] channel_out
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [15:0] cfg_wdata
);

	mlpd_pkg::blk_arr_t blk_len_q;
	logic               push_valid;
	logic               push_ready;
	mlpd_pkg::item_t    push_item;
	logic               q_valid;
	logic               q_ready;
	mlpd_pkg::item_t    q_item;
	mlpd_pkg::res_t     out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mlpd_pkg::NUM_REGS; i++) begin
				blk_len_q[i] <= mlpd_pkg::BLK_RESET[i];
			end
		end else if (cfg_we && ({29'd0, cfg_idx} < 32'(mlpd_pkg::NUM_REGS))) begin
			blk_len_q[cfg_idx] <= cfg_wdata;
		end
	end

	mlpd_front #(
		.CHANNELS(CHANNELS)
	) u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item (push_item)
	);

	mlpd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item (push_item),
		.pop_valid (q_valid),
		.pop_ready (q_ready),
		.pop_item  (q_item)
	);

	mlpd_back #(
		.CHANNELS(CHANNELS),
		.LEVELS  (LEVELS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.blk_len  (blk_len_q),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_item   (q_item),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res  (out_res),
		.out_last (m_tlast)
	);

	assign m_tdata = {out_res.hi, out_res.lo};
	assign m_tuser = {out_res.ch, out_res.level};

endmodule

[src/mlpd_queue.sv]
`include "multi_level_peak_decimator_unit_defines.svh"

module mlpd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  mlpd_pkg::item_t push_item,
	output logic           pop_valid,
	input  logic           pop_ready,
	output mlpd_pkg::item_t pop_item
);

	localparam int DEPTH = mlpd_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	mlpd_pkg::item_t    mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (cnt_q != CNT_W'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	`MLPD_ASSERT(a_cnt_range, cnt_q <= CNT_W'(DEPTH), "queue count beyond depth")
	`MLPD_ASSERT_NEXT(a_pop_empties, (cnt_q == CNT_W'(1)) && do_pop && !do_push, !pop_valid, "queue not empty after last pop")

endmodule

[src/mlpd_front.sv]
module mlpd_front #(
	parameter int CHANNELS = 2
) (
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [15:0]               s_tdata,
	input  logic [0:0]                s_tuser,
	output logic                      push_valid,
	input  logic                      push_ready,
	output mlpd_pkg::item_t           push_item
);

	logic drop;

	assign drop     = ({31'd0, s_tuser} >= 32'(CHANNELS));
	assign s_tready = push_ready;

	always_comb begin
		push_valid       = s_tvalid && !drop;
		push_item.ch     = s_tuser[0];
		push_item.sample = s_tdata;
		push_item.code0  = mlpd_pkg::map_code(s_tdata);
	end

endmodule

[src/mlpd_back.sv]
`include "multi_level_peak_decimator_unit_defines.svh"

module mlpd_back #(
	parameter int CHANNELS = 2,
	parameter int LEVELS   = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mlpd_pkg::blk_arr_t blk_len,
	input  logic               q_valid,
	output logic               q_ready,
	input  mlpd_pkg::item_t    q_item,
	output logic               out_valid,
	input  logic               out_ready,
	output mlpd_pkg::res_t     out_res,
	output logic               out_last
);

	localparam int NCH     = (CHANNELS > 2) ? 2 : CHANNELS;
	localparam int ENTRIES = NCH * LEVELS;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int LV_W    = $clog2(LEVELS + 2);
	localparam logic [LV_W-1:0] LAST_LV  = LV_W'(LEVELS);
	localparam logic [LV_W-1:0] FLUSH_LV = LV_W'(LEVELS + 1);

	logic                                 busy_q;
	logic [LV_W-1:0]                      lv_q;
	mlpd_pkg::item_t                      item_q;
	logic                                 pend_valid_q;
	mlpd_pkg::res_t                       pend_q;
	logic                                 out_valid_q;
	mlpd_pkg::res_t                       out_q;
	logic                                 out_last_q;
	logic signed [mlpd_pkg::SAMPLE_W-1:0] run_min_q [ENTRIES];
	logic signed [mlpd_pkg::SAMPLE_W-1:0] run_max_q [ENTRIES];
	logic [mlpd_pkg::BLK_W-1:0]           run_cnt_q [ENTRIES];

	logic [LV_W-1:0]                      lv_m1;
	logic [IDX_W-1:0]                     ent_idx;
	mlpd_pkg::blk_len_t                   blk;
	logic signed [mlpd_pkg::SAMPLE_W-1:0] new_min;
	logic signed [mlpd_pkg::SAMPLE_W-1:0] new_max;
	logic [mlpd_pkg::BLK_W:0]             cnt_inc;
	logic                                 complete;
	logic                                 is_step;
	logic                                 is_flush;
	logic                                 res_v;
	mlpd_pkg::res_t                       new_res;
	logic                                 out_free;
	logic                                 step_fire;
	logic                                 flush_fire;
	logic                                 pop;
	logic                                 out_load;

	always_comb begin
		is_step  = busy_q && (lv_q <= LAST_LV);
		is_flush = busy_q && (lv_q == FLUSH_LV);
		lv_m1    = (lv_q == '0 || lv_q > LAST_LV) ? '0 : lv_q - 1'b1;
		ent_idx  = (item_q.ch ? IDX_W'(LEVELS) : '0) + IDX_W'(lv_m1);
		blk      = blk_len[mlpd_pkg::REG_IDX_W'(lv_m1)];
		new_min  = (item_q.sample < run_min_q[ent_idx]) ? item_q.sample : run_min_q[ent_idx];
		new_max  = (item_q.sample > run_max_q[ent_idx]) ? item_q.sample : run_max_q[ent_idx];
		cnt_inc  = {1'b0, run_cnt_q[ent_idx]} + 1'b1;
		complete = (cnt_inc >= {1'b0, blk});
		res_v    = is_step && ((lv_q == '0) || complete);
		new_res.ch = item_q.ch;
		if (lv_q == '0) begin
			new_res.level = '0;
			new_res.lo    = item_q.code0;
			new_res.hi    = item_q.code0;
		end else begin
			new_res.level = mlpd_pkg::LEVEL_W'(lv_q);
			new_res.lo    = mlpd_pkg::map_code(new_min);
			new_res.hi    = mlpd_pkg::map_code(new_max);
		end
		out_free   = !out_valid_q || out_ready;
		step_fire  = is_step && !(res_v && pend_valid_q && !out_free);
		flush_fire = is_flush && out_free;
		pop        = q_valid && (!busy_q || flush_fire);
		out_load   = (step_fire && res_v && pend_valid_q) || flush_fire;
	end

	assign q_ready   = pop;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;
	assign out_last  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			lv_q         <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < ENTRIES; i++) begin
				run_min_q[i] <= mlpd_pkg::RUN_MIN_RESET;
				run_max_q[i] <= mlpd_pkg::RUN_MAX_RESET;
				run_cnt_q[i] <= '0;
			end
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				lv_q   <= '0;
			end else if (flush_fire) begin
				busy_q <= 1'b0;
			end else if (step_fire) begin
				lv_q <= lv_q + 1'b1;
			end
			if (step_fire && res_v) begin
				pend_valid_q <= 1'b1;
			end else if (flush_fire) begin
				pend_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (step_fire && lv_q != '0) begin
				if (complete) begin
					run_min_q[ent_idx] <= mlpd_pkg::RUN_MIN_RESET;
					run_max_q[ent_idx] <= mlpd_pkg::RUN_MAX_RESET;
					run_cnt_q[ent_idx] <= '0;
				end else begin
					run_min_q[ent_idx] <= new_min;
					run_max_q[ent_idx] <= new_max;
					run_cnt_q[ent_idx] <= cnt_inc[mlpd_pkg::BLK_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= q_item;
		end
		if (step_fire && res_v) begin
			pend_q <= new_res;
		end
		if (out_load) begin
			out_q      <= pend_q;
			out_last_q <= flush_fire;
		end
	end

	`MLPD_ASSERT(a_flush_has_pend, is_flush |-> pend_valid_q, "flush without a pending result")
	`MLPD_ASSERT(a_lv0_no_pend, (busy_q && lv_q == '0) |-> !pend_valid_q, "stale result at level zero")
	`MLPD_ASSERT(a_no_pop_mid_item, (busy_q && !flush_fire) |-> !pop, "request popped mid item")
	`MLPD_ASSERT_NEXT(a_flush_marks_last, flush_fire, out_valid_q && out_last_q, "final result not marked last")

endmodule
